>>> rtl/qai_pkg.sv
package qai_pkg;

	// controller states
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SQ,
		ST_W1,
		ST_P2,
		ST_W2,
		ST_P3,
		ST_P4,
		ST_DIVS,
		ST_DIVW,
		ST_TV,
		ST_W4,
		ST_HAM,
		ST_W5,
		ST_MAG,
		ST_NRM,
		ST_SS,
		ST_W6,
		ST_SQRT,
		ST_DONE
	} state_t;

	// multiplier operations
	typedef enum logic [2:0] {
		MOP_NONE,
		MOP_SQ,
		MOP_P2,
		MOP_P3,
		MOP_P4,
		MOP_TV,
		MOP_HAM,
		MOP_SS
	} mop_t;

	typedef struct packed {
		logic       init;
		logic       op_load;
		mop_t       mop;
		logic [3:0] midx;
		logic       div_start;
		logic [3:0] div_sel;
		logic       mag;
		logic       shr;
		logic       shl;
		logic       sqrt_step;
		logic       commit;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic m_zero;
		logic m_hi;
		logic m_lo;
		logic sqrt_last;
	} stat_t;

	localparam logic       OP_LOAD         = 1'b1;
	localparam logic [3:0] CNT_VEC_LAST    = 4'd2;
	localparam logic [3:0] CNT_HAM_LAST    = 4'd15;
	localparam logic [3:0] CNT_SS_LAST     = 4'd3;
	localparam logic [3:0] DIV_LAST_SERIES = 4'd7;
	localparam logic [3:0] DIV_FIRST_NORM  = 4'd8;
	localparam logic [3:0] DIV_LAST_NORM   = 4'd11;

	// sign of each hamilton product term, bit = row * 4 + column
	localparam logic [15:0] HAM_NEG = 16'h284E;

	// series divisors: sine terms first, then cosine terms
	function automatic logic [31:0] div_const(input logic [2:0] k);
		logic [31:0] v;
		unique case (k)
			3'd0: v = 32'd48;
			3'd1: v = 32'd3840;
			3'd2: v = 32'd645120;
			3'd3: v = 32'd185794560;
			3'd4: v = 32'd8;
			3'd5: v = 32'd384;
			3'd6: v = 32'd46080;
			3'd7: v = 32'd10321920;
			default: v = 32'd1;
		endcase
		return v;
	endfunction

endpackage

>>> rtl/quaternion_attitude_integrator.sv
// channel  dir  tdata                                   tuser
// s_       in   rot_x rot_y rot_z load_w load_x load_y  operation
//               load_z (32 bits each, lowest first)
// m_       out  att_w att_x att_y att_z (32 bits each)  none
//
// a load item is copied into the result register on accept and committed from the
// done state; a rotate item runs 12 divisions on the shared divider (4 quotient
// bits per cycle), 16 product terms, the normalizing shifts and a 32 step square
// root; a zero product skips the shifts, the square root and the last divisions
// reset leaves the attitude at the identity quaternion
// one item is in work at a time; a finished item waits in the output
// register, and a further item may be accepted while it waits
module quaternion_attitude_integrator #(
	parameter int FRAC_BITS = 30
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [223:0] s_tdata,  // rot_x, rot_y, rot_z, load_w, load_x, load_y, load_z
	input  logic         s_tuser,  // operation
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata   // att_w, att_x, att_y, att_z
);

	qai_pkg::cmd_t  cmd;
	qai_pkg::stat_t stat;

	// sequencer
	qai_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.op        (s_tuser),
		.in_ready  (s_tready),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.stat      (stat),
		.cmd       (cmd)
	);

	// arithmetic and attitude register, which also serves as output register
	qai_dp #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.in_data (s_tdata),
		.stat    (stat),
		.att     (m_tdata)
	);

	// nothing but setup is issued while waiting for an item
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (cmd.mop == qai_pkg::MOP_NONE && !cmd.div_start && !cmd.commit))
		else $error("work issued while idle");

	// a committed item shows up as a valid result
	a_commit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> m_tvalid)
		else $error("commit without result");

	// an accepted item blocks further input until it is done
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second item accepted during work");

	// divider completion is a single cycle pulse
	a_div_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_done |=> !stat.div_done)
		else $error("divider done held");

endmodule

>>> rtl/qai_div.sv
module qai_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [63:0] quotient
);

	logic        busy_q, done_q;
	logic [3:0]  cnt_q;
	logic [63:0] sh_q, sh_d;
	logic [31:0] rem_q, rem_d, dsr_q;

	// four restoring steps per cycle
	always_comb begin
		logic [32:0] trial;
		sh_d  = sh_q;
		rem_d = rem_q;
		for (int i = 0; i < 4; i++) begin
			trial = {rem_d, sh_d[63]};
			sh_d  = {sh_d[62:0], 1'b0};
			if (trial >= {1'b0, dsr_q}) begin
				rem_d    = 32'(trial - {1'b0, dsr_q});
				sh_d[0]  = 1'b1;
			end else begin
				rem_d = trial[31:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == 4'd15);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd15)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			sh_q  <= sh_d;
			rem_q <= rem_d;
		end
	end

	assign done     = done_q;
	assign quotient = sh_q;

endmodule

>>> rtl/qai_dp.sv
module qai_dp #(
	parameter int FRAC_BITS = 30
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  qai_pkg::cmd_t        cmd,
	input  logic [223:0]         in_data,
	output qai_pkg::stat_t       stat,
	output logic [127:0]         att
);

	localparam logic [63:0] HALF = 64'd1 << (FRAC_BITS - 1);
	localparam logic [63:0] ONE  = 64'd1 << FRAC_BITS;
	localparam logic [63:0] NCAP = (64'd2 << FRAC_BITS) - 64'd1;

	logic signed [31:0] a_q [3];
	logic signed [31:0] quat_q [4];
	logic signed [31:0] res_q [4];
	logic signed [31:0] t_q [3];
	logic signed [65:0] d_q [4];
	logic [64:0]        m_q [4];
	logic [63:0]        sq_q, sum_q, r_q, bit_q;
	logic [31:0]        p2_q;
	logic [32:0]        p3_q;
	logic [33:0]        p4_q;
	logic signed [33:0] s_q, c_q;

	qai_pkg::mop_t      mop_s1;
	logic [3:0]         midx_s1;
	logic signed [65:0] prod_s1;
	logic [3:0]         div_sel_q;

	logic [63:0]        sq_rnd, n_full;
	logic [30:0]        n_w;
	logic signed [32:0] ma, mb;
	logic signed [65:0] rnd_s, rsh;
	logic [63:0]        div_dnd, div_quo, sqrt_trial;
	logic [31:0]        div_dsr, div_k;
	logic [63:0]        div_src;
	logic               div_done;
	logic [1:0]         row, col, row_s1;

	// squared length of the increment, rounded and capped
	assign sq_rnd = sq_q + HALF;
	assign n_full = sq_rnd >> FRAC_BITS;
	assign n_w    = (n_full > NCAP) ? NCAP[30:0] : n_full[30:0];

	assign row    = cmd.midx[3:2];
	assign col    = cmd.midx[1:0];
	assign row_s1 = midx_s1[3:2];

	// shared multiplier operand select
	always_comb begin
		ma = '0;
		mb = '0;
		unique case (cmd.mop)
			qai_pkg::MOP_SQ: begin
				ma = 33'(a_q[col]);
				mb = 33'(a_q[col]);
			end
			qai_pkg::MOP_P2: begin
				ma = {2'b0, n_w};
				mb = {2'b0, n_w};
			end
			qai_pkg::MOP_P3: begin
				ma = {2'b0, n_w};
				mb = {1'b0, p2_q};
			end
			qai_pkg::MOP_P4: begin
				ma = {1'b0, p2_q};
				mb = {1'b0, p2_q};
			end
			qai_pkg::MOP_TV: begin
				ma = s_q[32:0];
				mb = 33'(a_q[col]);
			end
			qai_pkg::MOP_HAM: begin
				ma = 33'(quat_q[row ^ col]);
				unique case (col)
					2'd0:    mb = c_q[32:0];
					2'd1:    mb = 33'(t_q[0]);
					2'd2:    mb = 33'(t_q[1]);
					default: mb = 33'(t_q[2]);
				endcase
			end
			qai_pkg::MOP_SS: begin
				ma = {3'b0, m_q[col][29:0]};
				mb = {3'b0, m_q[col][29:0]};
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	assign rnd_s = prod_s1 + $signed({2'b0, HALF});
	assign rsh   = rnd_s >>> FRAC_BITS;

	// divider operands
	always_comb begin
		div_k = qai_pkg::div_const(cmd.div_sel[2:0]);
		unique case (cmd.div_sel[1:0])
			2'd0:    div_src = {33'b0, n_w};
			2'd1:    div_src = {32'b0, p2_q};
			2'd2:    div_src = {31'b0, p3_q};
			default: div_src = {30'b0, p4_q};
		endcase
		if (cmd.div_sel >= qai_pkg::DIV_FIRST_NORM) begin
			div_dnd = ({34'b0, m_q[cmd.div_sel[1:0]][29:0]} << FRAC_BITS) + (r_q >> 1);
			div_dsr = r_q[31:0];
		end else begin
			div_dnd = div_src + {33'b0, div_k[31:1]};
			div_dsr = div_k;
		end
	end

	qai_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dnd),
		.divisor  (div_dsr),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign sqrt_trial = r_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mop_s1 <= qai_pkg::MOP_NONE;
			quat_q[0] <= 32'(ONE);
			quat_q[1] <= '0;
			quat_q[2] <= '0;
			quat_q[3] <= '0;
		end else begin
			mop_s1 <= cmd.mop;
			if (cmd.commit) begin
				for (int i = 0; i < 4; i++)
					quat_q[i] <= res_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= ma * mb;
		midx_s1 <= cmd.midx;
		if (cmd.div_start)
			div_sel_q <= cmd.div_sel;

		if (cmd.init) begin
			sq_q  <= '0;
			sum_q <= '0;
			r_q   <= '0;
			bit_q <= 64'd1 << 62;
			s_q   <= HALF[33:0];
			c_q   <= ONE[33:0];
			for (int i = 0; i < 4; i++) begin
				d_q[i] <= '0;
				res_q[i] <= (cmd.op_load == qai_pkg::OP_LOAD) ?
					in_data[96 + 32*i +: 32] : '0;
			end
			for (int i = 0; i < 3; i++)
				a_q[i] <= in_data[32*i +: 32];
		end

		unique case (mop_s1)
			qai_pkg::MOP_SQ:  sq_q <= sq_q + prod_s1[63:0];
			qai_pkg::MOP_P2:  p2_q <= rsh[31:0];
			qai_pkg::MOP_P3:  p3_q <= rsh[32:0];
			qai_pkg::MOP_P4:  p4_q <= rsh[33:0];
			qai_pkg::MOP_TV:  t_q[midx_s1[1:0]] <= rsh[31:0];
			qai_pkg::MOP_HAM: begin
				if (qai_pkg::HAM_NEG[midx_s1])
					d_q[row_s1] <= d_q[row_s1] - prod_s1;
				else
					d_q[row_s1] <= d_q[row_s1] + prod_s1;
			end
			qai_pkg::MOP_SS:  sum_q <= sum_q + prod_s1[63:0];
			default: ;
		endcase

		if (cmd.mag) begin
			for (int i = 0; i < 4; i++)
				m_q[i] <= d_q[i][65] ? 65'(-d_q[i]) : 65'(d_q[i]);
		end else if (cmd.shr) begin
			for (int i = 0; i < 4; i++)
				m_q[i] <= m_q[i] >> 1;
		end else if (cmd.shl) begin
			for (int i = 0; i < 4; i++)
				m_q[i] <= m_q[i] << 1;
		end

		// bitwise integer square root
		if (cmd.sqrt_step) begin
			if (sum_q >= sqrt_trial) begin
				sum_q <= sum_q - sqrt_trial;
				r_q   <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end

		if (div_done) begin
			if (div_sel_q < qai_pkg::DIV_FIRST_NORM) begin
				if (div_sel_q[2]) begin
					if (div_sel_q[0])
						c_q <= c_q + $signed({2'b0, div_quo[31:0]});
					else
						c_q <= c_q - $signed({2'b0, div_quo[31:0]});
				end else begin
					if (div_sel_q[0])
						s_q <= s_q + $signed({2'b0, div_quo[31:0]});
					else
						s_q <= s_q - $signed({2'b0, div_quo[31:0]});
				end
			end else begin
				res_q[div_sel_q[1:0]] <= d_q[div_sel_q[1:0]][65] ?
					-$signed(div_quo[31:0]) : $signed(div_quo[31:0]);
			end
		end
	end

	always_comb begin
		stat.div_done  = div_done;
		stat.sqrt_last = bit_q[0];
		stat.m_zero    = 1'b1;
		stat.m_hi      = 1'b0;
		stat.m_lo      = 1'b1;
		for (int i = 0; i < 4; i++) begin
			if (m_q[i] != '0)
				stat.m_zero = 1'b0;
			if (|m_q[i][64:30])
				stat.m_hi = 1'b1;
			if (|m_q[i][64:29])
				stat.m_lo = 1'b0;
		end
	end

	assign att = {quat_q[3], quat_q[2], quat_q[1], quat_q[0]};

endmodule

>>> rtl/qai_ctrl.sv
module qai_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            op,
	output logic            in_ready,
	input  logic            out_ready,
	output logic            out_valid,
	input  qai_pkg::stat_t  stat,
	output qai_pkg::cmd_t   cmd
);

	qai_pkg::state_t state_q, state_d;
	logic [3:0]      cnt_q, cnt_d;
	logic            out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= qai_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.commit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		in_ready = (state_q == qai_pkg::ST_IDLE);
		unique case (state_q)
			qai_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.init    = 1'b1;
					cmd.op_load = op;
					cnt_d       = '0;
					state_d     = (op == qai_pkg::OP_LOAD) ? qai_pkg::ST_DONE : qai_pkg::ST_SQ;
				end
			end
			qai_pkg::ST_SQ: begin
				cmd.mop  = qai_pkg::MOP_SQ;
				cmd.midx = cnt_q;
				if (cnt_q == qai_pkg::CNT_VEC_LAST) begin
					cnt_d   = '0;
					state_d = qai_pkg::ST_W1;
				end else begin
					cnt_d = cnt_q + 4'd1;
				end
			end
			qai_pkg::ST_W1: state_d = qai_pkg::ST_P2;
			qai_pkg::ST_P2: begin
				cmd.mop = qai_pkg::MOP_P2;
				state_d = qai_pkg::ST_W2;
			end
			qai_pkg::ST_W2: state_d = qai_pkg::ST_P3;
			qai_pkg::ST_P3: begin
				cmd.mop = qai_pkg::MOP_P3;
				state_d = qai_pkg::ST_P4;
			end
			qai_pkg::ST_P4: begin
				cmd.mop = qai_pkg::MOP_P4;
				cnt_d   = '0;
				state_d = qai_pkg::ST_DIVS;
			end
			qai_pkg::ST_DIVS: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = cnt_q;
				state_d       = qai_pkg::ST_DIVW;
			end
			qai_pkg::ST_DIVW: begin
				if (stat.div_done) begin
					priority if (cnt_q == qai_pkg::DIV_LAST_SERIES) begin
						cnt_d   = '0;
						state_d = qai_pkg::ST_TV;
					end else if (cnt_q == qai_pkg::DIV_LAST_NORM) begin
						state_d = qai_pkg::ST_DONE;
					end else begin
						cnt_d   = cnt_q + 4'd1;
						state_d = qai_pkg::ST_DIVS;
					end
				end
			end
			qai_pkg::ST_TV: begin
				cmd.mop  = qai_pkg::MOP_TV;
				cmd.midx = cnt_q;
				if (cnt_q == qai_pkg::CNT_VEC_LAST) begin
					cnt_d   = '0;
					state_d = qai_pkg::ST_W4;
				end else begin
					cnt_d = cnt_q + 4'd1;
				end
			end
			qai_pkg::ST_W4: state_d = qai_pkg::ST_HAM;
			qai_pkg::ST_HAM: begin
				cmd.mop  = qai_pkg::MOP_HAM;
				cmd.midx = cnt_q;
				if (cnt_q == qai_pkg::CNT_HAM_LAST) begin
					cnt_d   = '0;
					state_d = qai_pkg::ST_W5;
				end else begin
					cnt_d = cnt_q + 4'd1;
				end
			end
			qai_pkg::ST_W5: state_d = qai_pkg::ST_MAG;
			qai_pkg::ST_MAG: begin
				cmd.mag = 1'b1;
				state_d = qai_pkg::ST_NRM;
			end
			qai_pkg::ST_NRM: begin
				priority if (stat.m_zero) begin
					state_d = qai_pkg::ST_DONE;
				end else if (stat.m_hi) begin
					cmd.shr = 1'b1;
				end else if (stat.m_lo) begin
					cmd.shl = 1'b1;
				end else begin
					cnt_d   = '0;
					state_d = qai_pkg::ST_SS;
				end
			end
			qai_pkg::ST_SS: begin
				cmd.mop  = qai_pkg::MOP_SS;
				cmd.midx = cnt_q;
				if (cnt_q == qai_pkg::CNT_SS_LAST) begin
					cnt_d   = '0;
					state_d = qai_pkg::ST_W6;
				end else begin
					cnt_d = cnt_q + 4'd1;
				end
			end
			qai_pkg::ST_W6: state_d = qai_pkg::ST_SQRT;
			qai_pkg::ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (stat.sqrt_last) begin
					cnt_d   = qai_pkg::DIV_FIRST_NORM;
					state_d = qai_pkg::ST_DIVS;
				end
			end
			qai_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.commit = 1'b1;
					state_d    = qai_pkg::ST_IDLE;
				end
			end
			default: state_d = qai_pkg::ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

>>> bench/attitude_checker.sv
`timescale 1ns / 100ps

module attitude_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [223:0] s_tdata,
	input  logic         s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [127:0] m_tdata,
	output int           fail_count,
	output int           pending
);

	localparam int FB = 30;
	localparam logic [63:0] ONE_Q = 64'sd1 << FB;
	localparam logic [63:0] HALF_Q = 64'sd1 << (FB - 1);

	logic signed [63:0] quat[4];
	logic [127:0] att_fifo[8];
	logic [2:0]   wr_ptr, rd_ptr;
	int fill;
	int mismatches;

	function automatic logic [63:0] rnd_div(input logic [63:0] u, input logic [63:0] c);
		return (u + c / 2) / c;
	endfunction

	function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// rotate the stored attitude by a rotation increment and renormalize
	task automatic apply_increment(input logic [95:0] rot);
		logic signed [63:0] a[3], t[4], d[4], s, c;
		logic [63:0] m[4], sq, n, p2, p3, p4, mx, sum, r, q;
		sq = 0;
		for (int i = 0; i < 3; i++) begin
			a[i] = $signed(rot[32*i +: 32]);
			sq += (a[i] < 0 ? -a[i] : a[i]) * (a[i] < 0 ? -a[i] : a[i]);
		end
		n = (sq + HALF_Q) >> FB;
		if (n > (64'd2 << FB) - 1) n = (64'd2 << FB) - 1;
		p2 = (n * n + HALF_Q) >> FB;
		p3 = (n * p2 + HALF_Q) >> FB;
		p4 = (p2 * p2 + HALF_Q) >> FB;
		s = HALF_Q - rnd_div(n, 48) + rnd_div(p2, 3840) - rnd_div(p3, 645120)
			+ rnd_div(p4, 185794560);
		c = ONE_Q - rnd_div(n, 8) + rnd_div(p2, 384) - rnd_div(p3, 46080)
			+ rnd_div(p4, 10321920);
		t[0] = c;
		// adding half before the arithmetic shift rounds the vector parts to nearest
		for (int i = 0; i < 3; i++) t[1+i] = (s * a[i] + $signed(HALF_Q)) >>> FB;
		d[0] = quat[0]*t[0] - quat[1]*t[1] - quat[2]*t[2] - quat[3]*t[3];
		d[1] = quat[1]*t[0] + quat[0]*t[1] - quat[3]*t[2] + quat[2]*t[3];
		d[2] = quat[2]*t[0] + quat[3]*t[1] + quat[0]*t[2] - quat[1]*t[3];
		d[3] = quat[3]*t[0] - quat[2]*t[1] + quat[1]*t[2] + quat[0]*t[3];
		mx = 0;
		for (int i = 0; i < 4; i++) begin
			m[i] = d[i] < 0 ? -d[i] : d[i];
			if (m[i] > mx) mx = m[i];
		end
		if (mx == 0) begin
			for (int i = 0; i < 4; i++) quat[i] = 0;
			return;
		end
		while (mx >= (64'd1 << 30)) begin
			mx >>= 1;
			for (int i = 0; i < 4; i++) m[i] >>= 1;
		end
		while (mx < (64'd1 << 29)) begin
			mx <<= 1;
			for (int i = 0; i < 4; i++) m[i] <<= 1;
		end
		sum = 0;
		for (int i = 0; i < 4; i++) sum += m[i] * m[i];
		r = floor_sqrt(sum);
		for (int i = 0; i < 4; i++) begin
			q = ((m[i] << FB) + r / 2) / r;
			quat[i] = d[i] < 0 ? -$signed(q) : $signed(q);
		end
	endtask

	assign pending = fill;

	always @(posedge clk or negedge arst_n) begin
		logic [127:0] want;
		if (!arst_n) begin
			quat[0] = ONE_Q;
			quat[1] = 0;
			quat[2] = 0;
			quat[3] = 0;
			wr_ptr = '0;
			rd_ptr = '0;
			fill = 0;
			fail_count <= 0;
			mismatches = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (fill == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected attitude item %h", m_tdata);
				end else begin
					want = att_fifo[rd_ptr];
					rd_ptr = rd_ptr + 3'd1;
					fill--;
					for (int i = 0; i < 4; i++) begin
						if (m_tdata[32*i +: 32] !== want[32*i +: 32]) begin
							mismatches++;
							if (mismatches <= 10)
								$display("attitude part %0d: expected %h got %h",
									i, want[32*i +: 32], m_tdata[32*i +: 32]);
						end
					end
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser) begin
					for (int i = 0; i < 4; i++) quat[i] = $signed(s_tdata[96 + 32*i +: 32]);
				end else begin
					apply_increment(s_tdata[95:0]);
				end
				for (int i = 0; i < 4; i++) want[32*i +: 32] = quat[i][31:0];
				if (fill == 8) begin
					mismatches++;
					if (mismatches <= 10) $display("too many attitude items outstanding");
				end else begin
					att_fifo[wr_ptr] = want;
					wr_ptr = wr_ptr + 3'd1;
					fill++;
				end
			end
			fail_count <= mismatches;
		end
	end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps

module testbench;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [223:0] s_tdata;
	logic         s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [127:0] m_tdata;
	int           fail_count;
	int           pending;
	int           cycles;

	localparam int ITEMS = 1700;
	// the limit covers rotate items plus long sender and receiver gaps
	localparam int CYCLE_LIMIT = ITEMS * 2500 + 50000;

	quaternion_attitude_integrator i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),   // rot_x, rot_y, rot_z, load_w, load_x, load_y, load_z
		.s_tuser (s_tuser),   // operation
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)    // att_w, att_x, att_y, att_z
	);

	attitude_checker i_checker (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// timeout watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// gap length: mostly short, some long, sometimes none for a stretch
	function automatic int gap_len(input bit calm);
		if (calm) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
		return $urandom_range(0, 3);
	endfunction

	// receiver stalls
	initial begin
		int g;
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			g = gap_len($urandom_range(0, 3) == 0);
			if (g > 0) begin
				m_tready <= 0;
				repeat (g) @(posedge clk);
			end
			m_tready <= 1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	// random angle: mostly small increments, sometimes full range
	function automatic logic [31:0] rnd_angle();
		case ($urandom_range(0, 9))
			0: return $urandom();
			1, 2: return $signed($urandom_range(0, 1 << 26)) - (1 << 25);
			default: return $signed($urandom_range(0, 1 << 22)) - (1 << 21);
		endcase
	endfunction

	function automatic logic [127:0] rnd_quat();
		logic [127:0] q;
		for (int i = 0; i < 4; i++)
			q[32*i +: 32] = $urandom_range(0, 3) == 0 ? $urandom()
				: $signed($urandom_range(0, 1 << 30)) - (1 << 29);
		return q;
	endfunction

	// valid stays high after accept; a gap drops it
	task automatic send_item(input logic op, input logic [95:0] rot, input logic [127:0] q);
		s_tvalid <= 1;
		s_tuser  <= op;
		s_tdata  <= {q, rot};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic send_gap(input bit calm);
		int g;
		g = gap_len(calm);
		if (g > 0) begin
			s_tvalid <= 0;
			repeat (g) @(posedge clk);
		end
	endtask

	localparam logic [31:0] MAXP = 32'h7FFF_FFFF;
	localparam logic [31:0] MINN = 32'h8000_0000;
	localparam logic [31:0] ONE  = 32'h4000_0000;

	initial begin
		bit calm;
		arst_n   = 0;
		s_tvalid = 0;
		s_tuser  = 0;
		s_tdata  = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: identity rotation, extremes, saturation, zero and odd loads
		send_item(1'b0, '0, '1);
		send_item(1'b0, {32'd0, 32'd0, 32'd1 << 20}, '0);
		send_item(1'b0, {MAXP, MAXP, MAXP}, '0);
		send_item(1'b0, {MINN, MINN, MINN}, '1);
		send_item(1'b0, {MINN, 32'd0, MAXP}, '0);
		send_item(1'b0, {32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF}, '0);
		send_item(1'b1, '1, {MAXP, MAXP, MAXP, MAXP});
		send_item(1'b0, '0, '0);
		send_item(1'b1, '0, {MINN, MINN, MINN, MINN});
		send_item(1'b0, {32'd0, 32'd1 << 24, 32'd0}, '0);
		// zero quaternion stays zero after a rotate
		send_item(1'b1, '1, '0);
		send_item(1'b0, {32'd1 << 22, 32'd1 << 22, 32'd1 << 22}, '0);
		send_item(1'b1, '0, {32'd0, 32'd0, 32'd0, ONE});
		send_item(1'b0, {32'd5 << 20, 32'hFFF0_0000, 32'd3 << 20}, '0);
		send_item(1'b1, '0, {32'd0, 32'd0, 32'd0, 32'd1});
		send_item(1'b0, '0, '0);
		send_item(1'b1, '0, {ONE, ONE, ONE, ONE});
		send_item(1'b0, {32'd1, 32'd1, 32'd1}, '0);

		for (int k = 0; k < ITEMS; k++) begin
			if (k % 60 == 0) calm = $urandom_range(0, 2) == 0;
			send_gap(calm);
			if ($urandom_range(0, 5) == 0)
				send_item(1'b1, {$urandom(), $urandom(), $urandom()}, rnd_quat());
			else
				send_item(1'b0, {rnd_angle(), rnd_angle(), rnd_angle()},
					{$urandom(), $urandom(), $urandom(), $urandom()});
		end
		s_tvalid <= 0;

		while (pending != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/qai_pkg.sv
rtl/qai_div.sv
rtl/qai_dp.sv
rtl/qai_ctrl.sv
rtl/quaternion_attitude_integrator.sv
bench/attitude_checker.sv
bench/testbench.sv
